>>> src/sbmq_pkg.sv
// ----------------------------------------------------------------------------
// sbmq_pkg
// Shared types and constants of the shared-buffer multi-queue: field widths,
// operation and status codes, and the command and status bundles that run
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package sbmq_pkg;

	localparam int NUM_SLOTS_DEF  = 64;
	localparam int NUM_QUEUES_DEF = 8;

	localparam int DATA_W   = 32;
	localparam int QID_W    = 3;
	localparam int STATUS_W = 2;

	localparam logic KIND_ENQ = 1'b0;
	localparam logic KIND_DEQ = 1'b1;

	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;

	localparam logic signed [DATA_W-1:0] UNDERFLOW_DATA = 32'sh7FFF_FFFF;

	// Controller to datapath.
	typedef struct packed {
		logic take;    // latch a request and issue the first table reads
		logic rd_dq;   // issue the link and value reads at the queue head
		logic fin_rd;  // finish an enqueue, or an operation that fails
		logic fin_dq;  // finish a dequeue that succeeds
	} cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic deq_go;  // latched request is a dequeue of a non-empty queue
	} sts_t;

endpackage

>>> src/sbmq_ctrl.sv
// ----------------------------------------------------------------------------
// sbmq_ctrl
// Sequencer of the shared-buffer multi-queue. Steps each request through the
// table reads and the commit, and owns the handshakes of both channels.
// ----------------------------------------------------------------------------
module sbmq_ctrl
	import sbmq_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	output logic rsp_valid,
	input  logic rsp_stall,
	input  sts_t sts,
	output cmd_t cmd
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_RD   = 2'd1;
	localparam logic [1:0] S_DQ   = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       rsp_valid_q;
	logic       out_free;
	logic       fin;

	// The result register can take a new beat when empty or when its beat
	// leaves in this cycle.
	assign out_free = !rsp_valid_q || !rsp_stall;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.take = 1'b1;
					state_d  = S_RD;
				end
			end
			S_RD: begin
				if (sts.deq_go) begin
					cmd.rd_dq = 1'b1;
					state_d   = S_DQ;
				end else if (out_free) begin
					cmd.fin_rd = 1'b1;
					state_d    = S_IDLE;
				end
			end
			S_DQ: begin
				if (out_free) begin
					cmd.fin_dq = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign fin = cmd.fin_rd || cmd.fin_dq;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (fin) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;

endmodule

>>> src/sbmq_dp.sv
// ----------------------------------------------------------------------------
// sbmq_dp
// Datapath of the shared-buffer multi-queue: slot value and link memories,
// per-queue head and tail memories, the free-list head, and the result
// register.
// ----------------------------------------------------------------------------
module sbmq_dp
	import sbmq_pkg::*;
#(
	parameter int NUM_SLOTS  = NUM_SLOTS_DEF,
	parameter int NUM_QUEUES = NUM_QUEUES_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  cmd_t                       cmd,
	output sts_t                       sts,
	input  logic                       kind,
	input  logic [QID_W-1:0]           queue_id,
	input  logic signed [DATA_W-1:0]   item,
	output logic signed [DATA_W-1:0]   data,
	output logic [STATUS_W-1:0]        status
);

	// Links carry one code more than there are slots: NUM_SLOTS is null.
	localparam int LW = $clog2(NUM_SLOTS + 1);
	localparam int SW = $clog2(NUM_SLOTS);
	localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
	localparam logic [LW-1:0] NULL_LINK = LW'(NUM_SLOTS);

	logic signed [DATA_W-1:0] value_mem [NUM_SLOTS];
	logic [LW-1:0]            link_mem  [NUM_SLOTS];
	logic [LW-1:0]            head_mem  [NUM_QUEUES];
	logic [SW-1:0]            tail_mem  [NUM_QUEUES];

	logic [NUM_QUEUES-1:0]    hv_q;
	logic [LW-1:0]            free_head_q;
	logic [LW-1:0]            fresh_q;

	logic                     kind_q;
	logic [QW-1:0]            qidx_q;
	logic                     qok_q;
	logic signed [DATA_W-1:0] item_q;

	logic [LW-1:0]            head_rd_q;
	logic                     head_vld_q;
	logic [SW-1:0]            tail_rd_q;
	logic [LW-1:0]            link_mem_q;
	logic                     link_fresh_q;
	logic [LW-1:0]            link_inc_q;
	logic signed [DATA_W-1:0] value_rd_q;

	logic signed [DATA_W-1:0] data_q;
	logic [STATUS_W-1:0]      status_q;

	logic [QW-1:0]            qidx_in;
	logic                     qok_in;
	logic [LW-1:0]            link_addr;
	logic [LW-1:0]            link_val;
	logic                     q_empty;
	logic                     enq_ok;
	logic                     enq_commit;
	logic [SW-1:0]            alloc_slot;
	logic [SW-1:0]            deq_slot;

	logic                     link_we;
	logic [SW-1:0]            link_wa;
	logic [LW-1:0]            link_wd;
	logic                     head_we;
	logic [LW-1:0]            head_wd;

	assign qidx_in = QW'(queue_id);
	assign qok_in  = (int'(queue_id) < NUM_QUEUES);

	// Slots at or above the fill count were never handed out, so their link
	// is taken as the next slot up instead of from the link memory.
	assign link_addr = cmd.take ? free_head_q : head_rd_q;
	assign link_val  = link_fresh_q ? link_inc_q : link_mem_q;

	assign q_empty    = !head_vld_q || (head_rd_q >= NULL_LINK);
	assign enq_ok     = qok_q && (free_head_q < NULL_LINK);
	assign enq_commit = cmd.fin_rd && (kind_q == KIND_ENQ) && enq_ok;
	assign alloc_slot = free_head_q[SW-1:0];
	assign deq_slot   = head_rd_q[SW-1:0];

	assign sts.deq_go = (kind_q == KIND_DEQ) && qok_q && !q_empty;

	// A slot's link is left alone when it becomes a tail; a dequeue instead
	// ends the queue when the head slot is also the tail slot.
	always_comb begin
		link_we = 1'b0;
		link_wa = deq_slot;
		link_wd = free_head_q;
		head_we = 1'b0;
		head_wd = link_val;
		if (enq_commit) begin
			if (q_empty) begin
				head_we = 1'b1;
				head_wd = LW'(alloc_slot);
			end else begin
				link_we = 1'b1;
				link_wa = tail_rd_q;
				link_wd = LW'(alloc_slot);
			end
		end else if (cmd.fin_dq) begin
			link_we = 1'b1;
			head_we = 1'b1;
			head_wd = (deq_slot == tail_rd_q) ? NULL_LINK : link_val;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take || cmd.rd_dq) begin
			link_mem_q   <= link_mem[link_addr[SW-1:0]];
			link_fresh_q <= (link_addr >= fresh_q);
			link_inc_q   <= link_addr + 1'b1;
		end
		if (link_we) begin
			link_mem[link_wa] <= link_wd;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_dq) begin
			value_rd_q <= value_mem[deq_slot];
		end
		if (enq_commit) begin
			value_mem[alloc_slot] <= item_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			head_rd_q <= head_mem[qidx_in];
			tail_rd_q <= tail_mem[qidx_in];
		end
		if (head_we) begin
			head_mem[qidx_q] <= head_wd;
		end
		if (enq_commit) begin
			tail_mem[qidx_q] <= alloc_slot;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			kind_q     <= kind;
			qidx_q     <= qidx_in;
			qok_q      <= qok_in;
			item_q     <= item;
			head_vld_q <= qok_in && hv_q[qidx_in];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hv_q        <= '0;
			free_head_q <= '0;
			fresh_q     <= '0;
		end else begin
			if (enq_commit) begin
				free_head_q <= link_val;
				if (link_fresh_q) begin
					fresh_q <= fresh_q + 1'b1;
				end
				if (q_empty) begin
					hv_q[qidx_q] <= 1'b1;
				end
			end else if (cmd.fin_dq) begin
				free_head_q <= head_rd_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fin_dq) begin
			data_q   <= value_rd_q;
			status_q <= ST_OK;
		end else if (cmd.fin_rd) begin
			if (kind_q == KIND_DEQ) begin
				data_q   <= UNDERFLOW_DATA;
				status_q <= ST_UNDERFLOW;
			end else begin
				data_q   <= '0;
				status_q <= enq_ok ? ST_OK : ST_OVERFLOW;
			end
		end
	end

	assign data   = data_q;
	assign status = status_q;

endmodule

>>> src/shared_buffer_multi_queue.sv
// ----------------------------------------------------------------------------
// shared_buffer_multi_queue
// Several FIFO queues that share one linked slot store with a free list.
// ----------------------------------------------------------------------------
// Each request beat is an enqueue or a dequeue on one queue and yields exactly
// one response beat with the dequeued value and a status (ok, overflow when no
// slot is free or the queue number is out of range, underflow when the queue
// is empty or out of range, with data 7FFFFFFF). An enqueue, or a dequeue that
// underflows, passes through the idle and read states, and a dequeue that
// returns an item also through the dequeue state, before the next request beat
// is taken; the finish waits while the response side stalls a result that is
// still waiting. The steps follow the chain of synchronous reads: head, tail and
// free-list link on taking the request, then, for a dequeue, the head slot's link and value. The
// request side can be accepted while an earlier response still waits. After
// reset all queues are empty and every slot is free; a fill count stands in
// for the initial free-list chain, so no clearing pass is needed and requests
// are taken from the first cycle after reset.
// ----------------------------------------------------------------------------
module shared_buffer_multi_queue
	import sbmq_pkg::*;
#(
	parameter int NUM_SLOTS  = NUM_SLOTS_DEF,
	parameter int NUM_QUEUES = NUM_QUEUES_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     req_valid,
	output logic                     req_stall,
	input  logic                     kind,
	input  logic [QID_W-1:0]         queue_id,
	input  logic signed [DATA_W-1:0] item,
	output logic                     rsp_valid,
	input  logic                     rsp_stall,
	output logic signed [DATA_W-1:0] data,
	output logic [STATUS_W-1:0]      status
);

	cmd_t cmd;
	sts_t sts;

	sbmq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	sbmq_dp #(
		.NUM_SLOTS  (NUM_SLOTS),
		.NUM_QUEUES (NUM_QUEUES)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.kind     (kind),
		.queue_id (queue_id),
		.item     (item),
		.data     (data),
		.status   (status)
	);

endmodule

>>> dv/tb_shared_buffer_multi_queue.sv
// ----------------------------------------------------------------------------
// tb_shared_buffer_multi_queue
// Self-checking bench for the shared-buffer multi-queue. A shadow copy of the
// slot store, link table, queue heads and tails and the free list predicts the
// data and status of every request beat at the moment it is accepted. A
// checker compares each response beat with the oldest prediction. Directed
// cases, a full-store pass, biased random traffic under several idle and stall
// mixes, a long response hold-off and a drain pause make up the run.
// ----------------------------------------------------------------------------
module tb_shared_buffer_multi_queue;
	import sbmq_pkg::*;

	localparam int SLOTS        = NUM_SLOTS_DEF;
	localparam int QUEUES       = NUM_QUEUES_DEF;
	localparam int NULL_SLOT    = SLOTS;
	localparam int DRAIN_CYCLES = 16;
	localparam int STUCK_LIMIT  = 3000;
	localparam int HOLD_CYCLES  = 400;

	localparam logic signed [DATA_W-1:0] INT_MIN_VAL = 32'sh8000_0000;
	localparam logic signed [DATA_W-1:0] INT_MAX_VAL = 32'sh7FFF_FFFF;

	typedef struct {
		logic signed [DATA_W-1:0] data;
		logic [STATUS_W-1:0]      status;
	} answer_t;

	logic                     clk;
	logic                     arst_n;
	logic                     req_valid;
	logic                     req_stall;
	logic                     kind;
	logic [QID_W-1:0]         queue_id;
	logic signed [DATA_W-1:0] item;
	logic                     rsp_valid;
	logic                     rsp_stall;
	logic signed [DATA_W-1:0] data;
	logic [STATUS_W-1:0]      status;

	// Shadow state of the block.
	logic signed [DATA_W-1:0] shadow_value [SLOTS];
	int                       shadow_link  [SLOTS];
	int                       shadow_head  [QUEUES];
	int                       shadow_tail  [QUEUES];
	int                       shadow_free;

	answer_t awaited_answers[$];
	answer_t oldest_answer;

	int send_idle_pct;
	int recv_stall_pct;
	int hold_off_cycles;
	int failures;
	int stuck_cycles;
	int n_requests;
	int n_deq_ok;
	int n_overflow;
	int n_underflow;
	int n_input_stalls;

	shared_buffer_multi_queue dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.kind      (kind),
		.queue_id  (queue_id),
		.item      (item),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.data      (data),
		.status    (status)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void reset_shadow();
		for (int i = 0; i < SLOTS; i++) begin
			shadow_value[i] = '0;
			shadow_link[i]  = (i + 1 < SLOTS) ? i + 1 : NULL_SLOT;
		end
		for (int i = 0; i < QUEUES; i++) begin
			shadow_head[i] = NULL_SLOT;
			shadow_tail[i] = 0;
		end
		shadow_free = 0;
	endfunction

	// Applies one operation to the shadow state and returns its answer.
	function automatic answer_t apply_queue_op(input logic op, input logic [QID_W-1:0] q,
		input logic signed [DATA_W-1:0] value);
		answer_t a;
		int      s;
		a.data   = '0;
		a.status = ST_OK;
		if (op == KIND_ENQ) begin
			if (int'(q) >= QUEUES || shadow_free >= SLOTS) begin
				a.status = ST_OVERFLOW;
			end else begin
				s           = shadow_free;
				shadow_free = shadow_link[s];
				if (shadow_head[q] >= SLOTS) begin
					shadow_head[q] = s;
				end else if (shadow_tail[q] < SLOTS) begin
					shadow_link[shadow_tail[q]] = s;
				end
				shadow_link[s]  = NULL_SLOT;
				shadow_tail[q]  = s;
				shadow_value[s] = value;
			end
		end else begin
			if (int'(q) >= QUEUES || shadow_head[q] >= SLOTS) begin
				a.status = ST_UNDERFLOW;
				a.data   = UNDERFLOW_DATA;
			end else begin
				s              = shadow_head[q];
				shadow_head[q] = shadow_link[s];
				shadow_link[s] = shadow_free;
				shadow_free    = s;
				a.data         = shadow_value[s];
			end
		end
		return a;
	endfunction

	// Called at a falling edge; returns at the falling edge after the beat is taken.
	task automatic send_op(input logic op, input logic [QID_W-1:0] q,
		input logic signed [DATA_W-1:0] value);
		answer_t a;
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		kind      <= op;
		queue_id  <= q;
		item      <= value;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		a = apply_queue_op(op, q, value);
		awaited_answers.push_back(a);
		n_requests++;
		if (a.status == ST_OVERFLOW) n_overflow++;
		else if (a.status == ST_UNDERFLOW) n_underflow++;
		else if (op == KIND_DEQ) n_deq_ok++;
		@(negedge clk);
	endtask

	task automatic wait_for_answers();
		while (awaited_answers.size() != 0) @(posedge clk);
		@(negedge clk);
	endtask

	function automatic logic signed [DATA_W-1:0] pick_value();
		case ($urandom_range(19))
			0: return INT_MIN_VAL;
			1: return INT_MAX_VAL;
			2: return '0;
			3: return -1;
			default: return $urandom;
		endcase
	endfunction

	task automatic test_directed();
		send_op(KIND_DEQ, 3'd0, $urandom);
		send_op(KIND_DEQ, 3'd7, $urandom);
		send_op(KIND_ENQ, 3'd0, INT_MIN_VAL);
		send_op(KIND_ENQ, 3'd0, INT_MAX_VAL);
		send_op(KIND_ENQ, 3'd7, 32'sd0);
		send_op(KIND_ENQ, 3'd7, -32'sd1);
		send_op(KIND_ENQ, 3'd3, 32'sh5555_5555);
		send_op(KIND_ENQ, 3'd3, 32'shAAAA_AAAA);
		send_op(KIND_ENQ, 3'd0, 32'sd1);
		send_op(KIND_DEQ, 3'd0, -32'sd1);
		send_op(KIND_DEQ, 3'd0, 32'sd0);
		send_op(KIND_DEQ, 3'd0, $urandom);
		send_op(KIND_DEQ, 3'd0, $urandom);
		send_op(KIND_DEQ, 3'd7, $urandom);
		send_op(KIND_DEQ, 3'd7, $urandom);
		send_op(KIND_DEQ, 3'd3, $urandom);
		send_op(KIND_DEQ, 3'd3, $urandom);
		send_op(KIND_DEQ, 3'd3, $urandom);
		// A real value equal to the underflow marker must still come back as ok.
		send_op(KIND_ENQ, 3'd6, INT_MAX_VAL);
		send_op(KIND_DEQ, 3'd6, $urandom);
	endtask

	// Fills every slot, overflows, frees one slot and reuses it, then drains all.
	task automatic test_store_full();
		send_op(KIND_ENQ, 3'd5, pick_value());
		for (int i = 1; i < SLOTS + 3; i++) send_op(KIND_ENQ, QID_W'($urandom), pick_value());
		send_op(KIND_DEQ, 3'd5, $urandom);
		send_op(KIND_ENQ, QID_W'($urandom), pick_value());
		send_op(KIND_ENQ, QID_W'($urandom), pick_value());
		for (int q = 0; q < QUEUES; q++) begin
			while (shadow_head[q] < SLOTS) send_op(KIND_DEQ, QID_W'(q), $urandom);
			send_op(KIND_DEQ, QID_W'(q), $urandom);
		end
	endtask

	// Alternates enqueue-heavy and dequeue-heavy bursts over a random range of
	// queues so that the store swings between full and empty.
	task automatic test_random_traffic(input int n_items);
		int enq_pct;
		int q_lo;
		int q_hi;
		enq_pct = 50;
		q_lo    = 0;
		q_hi    = QUEUES - 1;
		for (int i = 0; i < n_items; i++) begin
			if (i % 40 == 0) begin
				enq_pct = ((i / 40) % 2 == 0) ? 75 : 30;
				q_lo    = $urandom_range(QUEUES - 1);
				q_hi    = $urandom_range(QUEUES - 1, q_lo);
			end
			if ($urandom_range(9) == 0) begin
				send_op(1'($urandom), QID_W'($urandom), $urandom);
			end else begin
				send_op(($urandom_range(99) < enq_pct) ? KIND_ENQ : KIND_DEQ,
					QID_W'($urandom_range(q_hi, q_lo)), pick_value());
			end
		end
	endtask

	// The response side holds off while requests keep coming, so the block
	// backs up and stalls its request side.
	task automatic test_response_hold_off();
		send_idle_pct   = 0;
		recv_stall_pct  = 0;
		hold_off_cycles = HOLD_CYCLES;
		for (int i = 0; i < 40; i++) send_op(1'($urandom), QID_W'($urandom), pick_value());
	endtask

	task automatic test_drain_pause();
		test_random_traffic(30);
		req_valid <= 1'b0;
		wait_for_answers();
		repeat (DRAIN_CYCLES) @(negedge clk);
		test_random_traffic(30);
	endtask

	// Response side: random stalls, or a counted hold-off when one is requested.
	always @(negedge clk) begin
		if (hold_off_cycles > 0) begin
			rsp_stall <= 1'b1;
			hold_off_cycles--;
		end else begin
			rsp_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (awaited_answers.size() == 0) begin
				$error("response beat with no request waiting: data %0d, status %0d",
					data, status);
				failures++;
			end else begin
				oldest_answer = awaited_answers.pop_front();
				if (data !== oldest_answer.data) begin
					$error("data: expected %0d, got %0d", oldest_answer.data, data);
					failures++;
				end
				if (status !== oldest_answer.status) begin
					$error("status: expected %0d, got %0d", oldest_answer.status, status);
					failures++;
				end
			end
		end
	end

	// Watchdog on cycles in which neither side moves a beat.
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && req_stall) n_input_stalls++;
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
				stuck_cycles = 0;
			end else begin
				stuck_cycles++;
				if (stuck_cycles >= STUCK_LIMIT) begin
					$display("FAIL shared_buffer_multi_queue");
					$finish;
				end
			end
		end
	end

	initial begin
		arst_n          = 1'b0;
		req_valid       = 1'b0;
		kind            = KIND_ENQ;
		queue_id        = '0;
		item            = '0;
		rsp_stall       = 1'b0;
		send_idle_pct   = 0;
		recv_stall_pct  = 0;
		hold_off_cycles = 0;
		failures        = 0;
		stuck_cycles    = 0;
		n_requests      = 0;
		n_deq_ok        = 0;
		n_overflow      = 0;
		n_underflow     = 0;
		n_input_stalls  = 0;
		reset_shadow();
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_directed();
		test_store_full();
		test_random_traffic(280);
		send_idle_pct = 66;
		test_random_traffic(280);
		send_idle_pct  = 0;
		recv_stall_pct = 66;
		test_random_traffic(280);
		send_idle_pct  = 29;
		recv_stall_pct = 29;
		test_random_traffic(280);
		test_response_hold_off();
		send_idle_pct  = 29;
		recv_stall_pct = 29;
		test_drain_pause();

		req_valid     <= 1'b0;
		recv_stall_pct = 0;
		wait_for_answers();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d requests: %0d good dequeues, %0d overflows, %0d underflows.",
			n_requests, n_deq_ok, n_overflow, n_underflow);
		$display("Request side was held back for %0d cycles; %0d mismatches seen.",
			n_input_stalls, failures);
		if (failures == 0 && awaited_answers.size() == 0) begin
			$display("PASS shared_buffer_multi_queue");
		end else begin
			$display("FAIL shared_buffer_multi_queue");
		end
		$finish;
	end

endmodule
